// File: rtl/pqm_pkg.sv
// Package: shared types and codes for the process queue manager.
`default_nettype none
package pqm_pkg;
  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_FIND   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] name_key;
    logic [3:0]  priority_req;
    logic [7:0]  process_class;
    logic        is_blocked;
    logic        is_suspended;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot_index;
    logic [1:0] queue_id;
    logic [3:0] entry_priority;
    logic [7:0] entry_class;
    logic [4:0] queue_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, reset scan index
    logic scan_step; // compare one slot, advance index
    logic walk_init; // start ordered walk at queue head
    logic walk_step; // advance walk one entry
    logic do_insert; // link new entry
    logic do_remove; // unlink found entry
    logic rsp_load;  // build response
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic walk_done;
  } sts_t;
endpackage
`default_nettype wire

// File: rtl/pqm_if.sv
// Interfaces: request and response channels.
`default_nettype none
interface pqm_req_if;
  pqm_pkg::req_t data;
  logic valid;
  logic ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pqm_rsp_if;
  pqm_pkg::rsp_t data;
  logic valid;
  logic ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/pqm_ctrl.sv
// Controller: sequences scan, walk, link update and response.
`default_nettype none
module pqm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire logic          out_busy,
  input  wire pqm_pkg::sts_t sts,
  output pqm_pkg::cmd_t      cmd,
  output logic               in_ready
);
  import pqm_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_WINI = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = (state_r == S_IDLE) && !out_busy;
    unique case (state_r)
      S_IDLE: if (in_fire) begin
        cmd.load = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_WINI;
      end
      S_WINI: begin
        cmd.walk_init = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.do_insert = 1'b1;
        cmd.do_remove = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        cmd.rsp_load = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/pqm_dp.sv
// Datapath: slot tables, queue pointers, search and link logic.
`default_nettype none
module pqm_dp #(
  parameter int SLOT_COUNT    = 16,
  parameter int PRIORITY_BITS = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pqm_pkg::req_t req,
  input  wire pqm_pkg::cmd_t cmd,
  output pqm_pkg::sts_t      sts,
  output pqm_pkg::rsp_t      rsp_nxt
);
  import pqm_pkg::*;
  localparam int IW = $clog2(SLOT_COUNT);
  localparam int PW = IW + 1;
  localparam logic [PW-1:0] NIL = PW'(SLOT_COUNT);

  logic                     valid_r [SLOT_COUNT];
  logic [63:0]              key_r   [SLOT_COUNT];
  logic [PRIORITY_BITS-1:0] prio_r  [SLOT_COUNT];
  logic [7:0]               cls_r   [SLOT_COUNT];
  logic [1:0]               q_r     [SLOT_COUNT];
  logic [PW-1:0]            next_r  [SLOT_COUNT];
  logic [PW-1:0]            prev_r  [SLOT_COUNT];
  logic [PW-1:0]            head_r  [4];
  logic [PW-1:0]            tail_r  [4];
  logic [PW-1:0]            size_r  [4];

  req_t          req_r;
  logic [PW-1:0] idx_r;      // scan index, SLOT_COUNT when done
  logic [PW-1:0] found_r;    // NIL if absent
  logic [PW-1:0] free_r;     // lowest free, NIL if full
  logic [PW-1:0] cur_r;      // walk position
  logic [PW-1:0] steps_r;
  logic [1:0]    status_r;

  logic [1:0]               nq;
  logic [PRIORITY_BITS-1:0] nprio;
  logic [IW-1:0]            ix, cx;
  assign nq    = {req_r.is_blocked, req_r.is_suspended};
  assign nprio = PRIORITY_BITS'(req_r.priority_req);
  assign ix    = idx_r[IW-1:0];
  assign cx    = cur_r[IW-1:0];

  assign sts.scan_done = (idx_r == NIL - PW'(1)) && cmd.scan_step;
  // ready queues walk past entries of equal or higher priority
  assign sts.walk_done = (cur_r == NIL) || (steps_r == NIL) || nq[1] ||
                         (status_r != ST_OK) || (req_r.kind != KIND_CREATE) ||
                         (prio_r[cx] < nprio);

  logic is_ins, is_rem;
  assign is_ins = cmd.do_insert && status_r == ST_OK && req_r.kind == KIND_CREATE;
  assign is_rem = cmd.do_remove && status_r == ST_OK && req_r.kind == KIND_REMOVE;

  logic [IW-1:0] fx, sx;
  assign fx = found_r[IW-1:0];
  assign sx = free_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) valid_r[i] <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        head_r[i] <= NIL;
        tail_r[i] <= NIL;
        size_r[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        req_r   <= req;
        idx_r   <= '0;
        found_r <= NIL;
        free_r  <= NIL;
      end
      if (cmd.scan_step) begin
        if (valid_r[ix] && key_r[ix] == req_r.name_key && found_r == NIL) found_r <= idx_r;
        if (!valid_r[ix] && free_r == NIL) free_r <= idx_r;
        idx_r <= idx_r + PW'(1);
      end
      if (cmd.walk_init) begin
        cur_r   <= nq[1] ? NIL : head_r[nq];
        steps_r <= '0;
        if (req_r.kind == KIND_CREATE)
          status_r <= (found_r != NIL) ? ST_DUP : (free_r == NIL) ? ST_FULL : ST_OK;
        else
          status_r <= (found_r == NIL) ? ST_MISSING : ST_OK;
      end
      if (cmd.walk_step && !sts.walk_done) begin
        cur_r   <= next_r[cx];
        steps_r <= steps_r + PW'(1);
      end
      if (is_ins) begin
        valid_r[sx] <= 1'b1;
        key_r[sx]   <= req_r.name_key;
        prio_r[sx]  <= nprio;
        cls_r[sx]   <= req_r.process_class;
        q_r[sx]     <= nq;
        size_r[nq]  <= size_r[nq] + PW'(1);
        if (cur_r == NIL) begin
          prev_r[sx] <= tail_r[nq];
          next_r[sx] <= NIL;
          if (tail_r[nq] != NIL) next_r[tail_r[nq][IW-1:0]] <= free_r;
          else head_r[nq] <= free_r;
          tail_r[nq] <= free_r;
        end else begin
          prev_r[sx] <= prev_r[cx];
          next_r[sx] <= cur_r;
          prev_r[cx] <= free_r;
          if (prev_r[cx] != NIL) next_r[prev_r[cx][IW-1:0]] <= free_r;
          else head_r[nq] <= free_r;
        end
      end
      if (is_rem) begin
        valid_r[fx] <= 1'b0;
        if (prev_r[fx] != NIL) next_r[prev_r[fx][IW-1:0]] <= next_r[fx];
        else head_r[q_r[fx]] <= next_r[fx];
        if (next_r[fx] != NIL) prev_r[next_r[fx][IW-1:0]] <= prev_r[fx];
        else tail_r[q_r[fx]] <= prev_r[fx];
        if (size_r[q_r[fx]] != '0) size_r[q_r[fx]] <= size_r[q_r[fx]] - PW'(1);
      end
    end
  end

  logic [IW-1:0] rx;
  assign rx = (req_r.kind == KIND_CREATE) ? sx : fx;
  always_comb begin
    rsp_nxt = '0;
    rsp_nxt.status = status_r;
    if (status_r == ST_OK) begin
      rsp_nxt.slot_index     = 4'(rx);
      rsp_nxt.queue_id       = q_r[rx];
      rsp_nxt.entry_priority = 4'(prio_r[rx]);
      rsp_nxt.entry_class    = cls_r[rx];
      rsp_nxt.queue_count    = 5'(size_r[q_r[rx]]);
    end
  end
endmodule
`default_nettype wire

// File: rtl/process_queue_manager.sv
// Top level: process queue manager with request and response channels.
`default_nettype none
// Holds SLOT_COUNT process slots in four linked queues (two priority-ordered
// ready queues, two FIFO blocked queues). Each request gives one response.
// A request is processed in order: the slot scan visits one slot a cycle, the
// walk steps through ready-queue entries on an ordered insert (none otherwise),
// the links are updated and the response is registered. The response register
// holds until taken; the next request is accepted from the cycle after the
// response transfer.
module process_queue_manager #(
  parameter int SLOT_COUNT    = 16,
  parameter int PRIORITY_BITS = 4
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pqm_req_if.sink     in_ch,
  pqm_rsp_if.source   out_ch
);
  import pqm_pkg::*;
  cmd_t cmd;
  sts_t sts;
  rsp_t rsp_nxt, rsp_r;
  logic out_valid_r;
  logic in_fire, out_fire;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_valid_r && out_ch.ready;

  pqm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_busy(out_valid_r),
    .sts(sts), .cmd(cmd), .in_ready(in_ch.ready)
  );

  pqm_dp #(.SLOT_COUNT(SLOT_COUNT), .PRIORITY_BITS(PRIORITY_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .req(in_ch.data), .cmd(cmd), .sts(sts),
    .rsp_nxt(rsp_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.rsp_load) out_valid_r <= 1'b1;
    else if (out_fire) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.rsp_load) rsp_r <= rsp_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = rsp_r;
endmodule
`default_nettype wire

// File: rtl/pqm_checker.sv
// Checker: port-level properties of the process queue manager.
`default_nettype none
module pqm_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire pqm_pkg::rsp_t out_data
);
  import pqm_pkg::*;
  // one request in flight: no acceptance while a response waits
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accept while response pending");
  // response never directly follows acceptance
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("response too early");
  // errors carry zero slot index and queue count
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |->
    (out_data.slot_index == '0 && out_data.queue_count == '0))
    else $error("nonzero payload on error");
  // stalled response holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("response dropped");
endmodule

bind process_queue_manager pqm_checker u_pqm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire
